// ===== hw/rtl/gcas_pkg.sv =====
// Shared types and codes for the receiver configuration sequencer.
// Used by gnss_config_ack_sequencer_core and its checker; no dependencies.
package gcas_pkg;

    typedef logic [3:0] t_step;
    typedef logic [2:0] t_op;
    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_fin;
    typedef logic [2:0] t_cfg_idx;

    // configuration steps
    localparam t_step STEP_PORT    = 4'd0;
    localparam t_step STEP_RATE    = 4'd1;
    localparam t_step STEP_ANT     = 4'd2;
    localparam t_step STEP_NAV     = 4'd3;
    localparam t_step STEP_TP      = 4'd4;
    localparam t_step STEP_PVT     = 4'd5;
    localparam t_step STEP_SAT     = 4'd6;
    localparam t_step STEP_POSLLH  = 4'd7;
    localparam t_step STEP_VELNED  = 4'd8;
    localparam t_step STEP_SOL     = 4'd9;
    localparam t_step STEP_TIMEGPS = 4'd10;
    localparam t_step STEP_READY   = 4'd11;
    localparam t_step STEP_ERROR   = 4'd12;

    // event codes
    localparam t_op OP_RESTART = 3'd0;
    localparam t_op OP_ACK     = 3'd1;
    localparam t_op OP_NAK     = 3'd2;
    localparam t_op OP_OTHER   = 3'd3;
    localparam t_op OP_EXPIRE  = 3'd4;

    // command kinds
    localparam t_kind KIND_NONE     = 3'd0;
    localparam t_kind KIND_PORT     = 3'd1;
    localparam t_kind KIND_RATE     = 3'd2;
    localparam t_kind KIND_ANT      = 3'd3;
    localparam t_kind KIND_NAV      = 3'd4;
    localparam t_kind KIND_TP       = 3'd5;
    localparam t_kind KIND_MSG_RATE = 3'd6;

    // completion codes
    localparam t_fin FIN_NONE = 2'd0;
    localparam t_fin FIN_DONE = 2'd1;
    localparam t_fin FIN_FAIL = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx CFG_RETRY_LIMIT  = 3'd0;
    localparam t_cfg_idx CFG_MEAS_RATE    = 3'd1;
    localparam t_cfg_idx CFG_MIN_ELEV     = 3'd2;
    localparam t_cfg_idx CFG_PORT_ID      = 3'd3;
    localparam t_cfg_idx CFG_INACT_LIMIT  = 3'd4;

    // register reset values
    localparam logic [3:0]  DEFAULT_RETRIES    = 4'd10;
    localparam logic [7:0]  DEFAULT_MEAS_RATE  = 8'd1;
    localparam logic [31:0] DEFAULT_INACTIVITY = 32'd5000000;

    localparam logic [31:0] PULSE_PERIOD = 32'd1000000;

    // command class and ids
    localparam logic [7:0] CLS_CFG    = 8'h06;
    localparam logic [7:0] CLS_NAV    = 8'h01;
    localparam logic [7:0] ID_PRT     = 8'h00;
    localparam logic [7:0] ID_RATE    = 8'h08;
    localparam logic [7:0] ID_ANT     = 8'h13;
    localparam logic [7:0] ID_NAV5    = 8'h24;
    localparam logic [7:0] ID_TP5     = 8'h31;
    localparam logic [7:0] ID_MSG     = 8'h01;
    localparam logic [7:0] ID_PVT     = 8'h07;
    localparam logic [7:0] ID_SAT     = 8'h35;
    localparam logic [7:0] ID_POSLLH  = 8'h02;
    localparam logic [7:0] ID_VELNED  = 8'h12;
    localparam logic [7:0] ID_SOL     = 8'h06;
    localparam logic [7:0] ID_TIMEGPS = 8'h20;

endpackage

// ===== hw/rtl/gnss_config_ack_sequencer_core.sv =====
// Receiver configuration sequencer: ack/nak handling, resend on timeout and
// an inactivity watchdog. Depends on gcas_pkg.
//
// Usage:
//   Event channel (i_in_valid / o_in_stall): one event per transfer, with an
//   operation code, the acknowledged class and id, a baud value and a
//   microsecond timestamp. Result channel (o_out_valid / i_out_stall): exactly
//   one result per event, in order, giving the step after the event, the
//   command to send with its argument, completion status and timer control.
//   Configuration channel (i_cfg_valid / o_cfg_ready): always ready; write
//   only while no event is in flight.
//   The event register feeds the decision logic, whose output lands in the
//   result register when that register advances. Throughput is one event
//   per cycle while the receiver does not stall; the rate is set by the state
//   update, which includes a 64-bit subtract and compare for the watchdog.
//   Reset leaves the block in the ready step with the timer stopped and both
//   registers empty. When the receiver stalls, the result holds, the event
//   register fills, and o_in_stall rises until the result is taken.
module gnss_config_ack_sequencer_core
    import gcas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_acked_class,
    input  logic [7:0]  i_acked_id,
    input  logic [31:0] i_baud_value,
    input  logic [63:0] i_now_us,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_step,
    output logic [2:0]  o_send_kind,
    output logic [7:0]  o_rate_msg_class,
    output logic [7:0]  o_rate_msg_id,
    output logic [31:0] o_send_arg,
    output logic [1:0]  o_finished,
    output logic        o_timer_arm,
    output logic        o_timer_mode,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // configuration registers
    logic [3:0]        r_retry_limit;
    logic [7:0]        r_meas_rate;
    logic signed [7:0] r_min_elev;
    logic [31:0]       r_inact_limit;

    // sequencer state
    t_step       r_step,    n_step;
    logic [15:0] r_pend,    n_pend;
    logic [3:0]  r_retries, n_retries;
    logic [31:0] r_baud,    n_baud;
    logic [63:0] r_last,    n_last;
    logic        r_running, n_running;
    logic        r_long,    n_long;

    // event register
    logic        r_in_valid;
    t_op         r_op;
    logic [7:0]  r_cls;
    logic [7:0]  r_id;
    logic [31:0] r_in_baud;
    logic [63:0] r_now;

    // result register
    logic        r_out_valid;
    t_step       r_o_step;
    t_kind       r_o_kind, n_kind;
    logic [7:0]  r_o_cls,  n_cls;
    logic [7:0]  r_o_id,   n_id;
    logic [31:0] r_o_arg,  n_arg;
    t_fin        r_o_fin,  n_fin;
    logic        r_o_arm,  n_arm;
    logic        r_o_mode;

    logic        adv;
    logic        in_xfer;
    logic        match;
    logic        do_run;
    logic        quiet;
    logic [63:0] since_msg;
    t_step       tgt;
    logic [7:0]  cmd_id;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign match     = (r_pend != 16'd0) && ({r_cls, r_id} == r_pend);
    assign since_msg = r_now - r_last;
    assign quiet     = since_msg < {32'd0, r_inact_limit};

    always_comb begin
        n_step    = r_step;
        n_pend    = r_pend;
        n_retries = r_retries;
        n_baud    = r_baud;
        n_last    = r_last;
        n_running = r_running;
        n_long    = r_long;
        n_kind    = KIND_NONE;
        n_cls     = 8'd0;
        n_id      = 8'd0;
        n_arg     = 32'd0;
        n_fin     = FIN_NONE;
        n_arm     = 1'b0;
        do_run    = 1'b0;
        tgt       = r_step;
        cmd_id    = 8'd0;

        if (r_op == OP_ACK || r_op == OP_NAK || r_op == OP_OTHER) begin
            n_last = r_now;
        end

        case (r_op)
            OP_RESTART: begin
                n_running = 1'b0;
                n_long    = 1'b0;
                n_pend    = 16'd0;
                n_retries = r_retry_limit;
                n_baud    = r_in_baud;
                n_last    = 64'd0;
                tgt       = STEP_PORT;
                do_run    = 1'b1;
            end
            OP_ACK: begin
                if (match) begin
                    n_running = 1'b0;
                    if (r_step == STEP_SAT) begin
                        tgt = STEP_TIMEGPS;
                    end else if (r_step < STEP_READY) begin
                        tgt = r_step + 4'd1;
                    end else begin
                        tgt = STEP_ERROR;
                    end
                    n_pend    = 16'd0;
                    n_retries = r_retry_limit;
                    do_run    = 1'b1;
                end
            end
            OP_NAK: begin
                if (match) begin
                    n_running = 1'b0;
                    // PVT not supported: fall back to the older messages
                    if (r_step == STEP_PVT) begin
                        tgt       = STEP_POSLLH;
                        n_retries = r_retry_limit;
                    end else begin
                        tgt = STEP_ERROR;
                    end
                    n_pend = 16'd0;
                    do_run = 1'b1;
                end
            end
            OP_EXPIRE: begin
                if (r_running) begin
                    n_running = 1'b0;
                    if (r_step == STEP_READY) begin
                        if (quiet) begin
                            n_running = 1'b1;
                            n_arm     = 1'b1;
                        end else begin
                            tgt    = STEP_ERROR;
                            do_run = 1'b1;
                        end
                    end else if (r_retries == 4'd0) begin
                        n_pend = 16'd0;
                        tgt    = STEP_ERROR;
                        do_run = 1'b1;
                    end else begin
                        // resend the current step
                        n_retries = r_retries - 4'd1;
                        do_run    = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (do_run) begin
            n_step = tgt;
            case (tgt)
                STEP_PORT:    begin n_kind = KIND_PORT; cmd_id = ID_PRT;  n_arg = n_baud; end
                STEP_RATE:    begin
                    n_kind = KIND_RATE;
                    cmd_id = ID_RATE;
                    n_arg  = {24'd0, r_meas_rate};
                end
                STEP_ANT:     begin n_kind = KIND_ANT; cmd_id = ID_ANT; end
                STEP_NAV:     begin
                    n_kind = KIND_NAV;
                    cmd_id = ID_NAV5;
                    n_arg  = {24'd0, r_min_elev};
                end
                STEP_TP:      begin n_kind = KIND_TP; cmd_id = ID_TP5; n_arg = PULSE_PERIOD; end
                STEP_PVT:     begin n_id = ID_PVT;     n_arg = 32'd1; end
                STEP_SAT:     begin n_id = ID_SAT;     n_arg = {24'd0, r_meas_rate}; end
                STEP_POSLLH:  begin n_id = ID_POSLLH;  n_arg = 32'd1; end
                STEP_VELNED:  begin n_id = ID_VELNED;  n_arg = 32'd1; end
                STEP_SOL:     begin n_id = ID_SOL;     n_arg = {24'd0, r_meas_rate}; end
                STEP_TIMEGPS: begin n_id = ID_TIMEGPS; n_arg = {24'd0, r_meas_rate}; end
                STEP_READY:   begin n_fin = FIN_DONE; n_long = 1'b1; end
                default:      begin n_step = STEP_ERROR; n_fin = FIN_FAIL; end
            endcase

            if (tgt >= STEP_PVT && tgt <= STEP_TIMEGPS) begin
                n_kind = KIND_MSG_RATE;
                n_cls  = CLS_NAV;
                cmd_id = ID_MSG;
            end
            if (n_kind != KIND_NONE) begin
                n_pend = {CLS_CFG, cmd_id};
            end

            n_running = (n_step != STEP_ERROR);
            n_arm     = (n_step != STEP_ERROR);
        end
    end

    // configuration writes; the port number is accepted but not stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= DEFAULT_RETRIES;
            r_meas_rate   <= DEFAULT_MEAS_RATE;
            r_min_elev    <= 8'sd0;
            r_inact_limit <= DEFAULT_INACTIVITY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[3:0];
                CFG_MEAS_RATE:   r_meas_rate   <= i_cfg_data[7:0];
                CFG_MIN_ELEV:    r_min_elev    <= i_cfg_data[7:0];
                CFG_PORT_ID:     begin end
                CFG_INACT_LIMIT: r_inact_limit <= i_cfg_data;
                default:         begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_READY;
            r_pend      <= 16'd0;
            r_retries   <= 4'd0;
            r_baud      <= 32'd0;
            r_last      <= 64'd0;
            r_running   <= 1'b0;
            r_long      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_step    <= n_step;
                    r_pend    <= n_pend;
                    r_retries <= n_retries;
                    r_baud    <= n_baud;
                    r_last    <= n_last;
                    r_running <= n_running;
                    r_long    <= n_long;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op      <= i_operation;
            r_cls     <= i_acked_class;
            r_id      <= i_acked_id;
            r_in_baud <= i_baud_value;
            r_now     <= i_now_us;
        end
        if (adv && r_in_valid) begin
            r_o_step <= n_step;
            r_o_kind <= n_kind;
            r_o_cls  <= n_cls;
            r_o_id   <= n_id;
            r_o_arg  <= n_arg;
            r_o_fin  <= n_fin;
            r_o_arm  <= n_arm;
            r_o_mode <= n_long;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_step           = r_o_step;
    assign o_send_kind      = r_o_kind;
    assign o_rate_msg_class = r_o_cls;
    assign o_rate_msg_id    = r_o_id;
    assign o_send_arg       = r_o_arg;
    assign o_finished       = r_o_fin;
    assign o_timer_arm      = r_o_arm;
    assign o_timer_mode     = r_o_mode;

endmodule

// ===== hw/rtl/gcas_checker.sv =====
// Port-level checks for gnss_config_ack_sequencer_core, bound to each instance of the core.
// Depends on gcas_pkg.
module gcas_checker
    import gcas_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_step,
    input logic [2:0]  o_send_kind,
    input logic [7:0]  o_rate_msg_class,
    input logic [7:0]  o_rate_msg_id,
    input logic [31:0] o_send_arg,
    input logic [1:0]  o_finished,
    input logic        o_timer_arm,
    input logic        o_timer_mode
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_step)
            && $stable(o_send_kind) && $stable(o_send_arg))
        else $error("result changed while stalled");

    // failure lands in the error step with the timer stopped
    a_fail_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished == FIN_FAIL |->
            o_step == STEP_ERROR && !o_timer_arm && o_send_kind == KIND_NONE)
        else $error("failure without error step");

    // success lands in ready with the timer armed in long mode
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished == FIN_DONE |->
            o_step == STEP_READY && o_timer_arm && o_timer_mode)
        else $error("success without ready step");

    // message-rate commands always target the navigation class
    a_msg_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_kind == KIND_MSG_RATE |->
            o_rate_msg_class == CLS_NAV && o_step >= STEP_PVT && o_step <= STEP_TIMEGPS)
        else $error("bad message-rate command");

    // no command means no argument and no message selection
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_kind == KIND_NONE |->
            o_send_arg == 32'd0 && o_rate_msg_class == 8'd0 && o_rate_msg_id == 8'd0)
        else $error("payload without command");

endmodule

bind gnss_config_ack_sequencer_core gcas_checker u_gcas_checker (.*);
